// ===== hw/rtl/eida_pkg.sv =====
// Shared types, codes and sizing constants for the entity identifier allocator.
`timescale 1ns / 1ps

package eida_pkg;

  // Sizing of the identifier space and the component set
  localparam int MAX_ENTITIES    = 256;
  localparam int COMPONENT_TYPES = 64;
  localparam int ID_LIMIT        = (MAX_ENTITIES < 256) ? MAX_ENTITIES : 256;
  localparam int ID_W            = 8;
  localparam int COMP_W          = 6;
  localparam int COMP_BITS       = 64;
  localparam int ACTION_W        = 3;
  localparam int STATUS_W        = 3;
  localparam int COUNT_W         = ID_W + 1;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE  = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_SET     = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_TEST    = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NO_FREE       = 3'd1,
    ST_BAD_ENTITY    = 3'd2,
    ST_BAD_COMPONENT = 3'd3,
    ST_QUEUE_FULL    = 3'd4
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming transaction and start memory reads
    logic execute;  // apply the operation, write back, load the result register
  } eida_cmd_t;

endpackage

// ===== hw/rtl/entity_id_allocator_with_components.sv =====
// Top level of the entity identifier allocator with component bitmaps.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: entity, component
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: new id, has_component, status
//
// Each transaction has a capture step, reading the bitmap and FIFO memories, and an
// execute step, updating them and loading the result register (one read-modify-write).
// The result register lets the next transaction be accepted while a result waits;
// execution stalls only while that register is still full and not taken.
// Reset clears only control state, counters and pointers; the memories need no clearing.
`timescale 1ns / 1ps

module entity_id_allocator_with_components (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] entity_id, [13:8] component_idx, [15:14] zero
  input  logic [eida_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] action
  input  logic [eida_pkg::ACTION_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] new_entity_id, [8] has_component, [11:9] status, [15:12] zero
  output logic [eida_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import eida_pkg::*;

  eida_cmd_t           cmd;
  logic [ID_W-1:0]     new_id;
  logic                has_comp;
  logic [STATUS_W-1:0] status;

  eida_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  eida_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (s_axis_tuser),
    .entity_id_i     (s_axis_tdata[ID_W-1:0]),
    .component_idx_i (s_axis_tdata[ID_W +: COMP_W]),
    .new_entity_id_o (new_id),
    .has_component_o (has_comp),
    .status_o        (status)
  );

  // Pack the result transaction
  assign m_axis_tdata = M_TDATA_W'({status, has_comp, new_id});

endmodule

// ===== hw/rtl/eida_ctrl.sv =====
// Controller state machine: input handshake, sequencing and result valid.
`timescale 1ns / 1ps

module eida_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output eida_pkg::eida_cmd_t cmd_o
);
  import eida_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   execute;

  // Accept only while idle; execute once the result register is free
  assign accept  = (state_q == S_IDLE) && s_axis_tvalid;
  assign execute = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  // Hold state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (execute) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (execute) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready  = (state_q == S_IDLE);
  assign m_axis_tvalid  = out_valid_q;
  assign cmd_o.capture  = accept;
  assign cmd_o.execute  = execute;

endmodule

// ===== hw/rtl/eida_dpath.sv =====
// Datapath: recycle FIFO, component bitmap memory, counters and result register.
`timescale 1ns / 1ps

module eida_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  eida_pkg::eida_cmd_t                cmd_i,
  input  logic [eida_pkg::ACTION_W-1:0]      action_i,
  input  logic [eida_pkg::ID_W-1:0]          entity_id_i,
  input  logic [eida_pkg::COMP_W-1:0]        component_idx_i,
  output logic [eida_pkg::ID_W-1:0]          new_entity_id_o,
  output logic                               has_component_o,
  output logic [eida_pkg::STATUS_W-1:0]      status_o
);
  import eida_pkg::*;

  localparam logic [ID_W-1:0]    PtrLast  = ID_W'(ID_LIMIT - 1);
  localparam logic [COUNT_W-1:0] CountMax = COUNT_W'(ID_LIMIT);
  localparam logic [COMP_W:0]    CompMax  = (COMP_W + 1)'(COMPONENT_TYPES);

  // Memories
  logic [ID_W-1:0]      fifo_mem [ID_LIMIT];
  logic [COMP_BITS-1:0] bits_mem [ID_LIMIT];

  // Control state
  logic [COUNT_W-1:0] fresh_q, fresh_d;
  logic [ID_W-1:0]    head_q, head_d;
  logic [ID_W-1:0]    tail_q, tail_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // Captured transaction and read data
  logic [ACTION_W-1:0]  action_q;
  logic [ID_W-1:0]      ent_q;
  logic [COMP_W-1:0]    comp_q;
  logic [ID_W-1:0]      fifo_rd_q;
  logic [COMP_BITS-1:0] bits_rd_q;

  // Result register
  logic [ID_W-1:0]     new_id_q, new_id_d;
  logic                has_q, has_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // Write ports
  logic                 fifo_we;
  logic                 bits_we;
  logic [ID_W-1:0]      bits_waddr;
  logic [COMP_BITS-1:0] bits_wdata;

  logic                 ent_ok;
  logic                 comp_ok;
  logic [COMP_BITS-1:0] mask;

  function automatic logic [ID_W-1:0] wrap_next(input logic [ID_W-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign ent_ok  = {1'b0, ent_q} < fresh_q;
  assign comp_ok = {1'b0, comp_q} < CompMax;
  assign mask    = COMP_BITS'(1) << comp_q;

  // Decode the operation and work out next state, writes and result
  always_comb begin
    fresh_d    = fresh_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    new_id_d   = '0;
    has_d      = 1'b0;
    status_d   = ST_OK;
    fifo_we    = 1'b0;
    bits_we    = 1'b0;
    bits_waddr = ent_q;
    bits_wdata = '0;
    priority if (action_q == ACT_CREATE) begin
      priority if (count_q != '0) begin
        new_id_d = fifo_rd_q;
        head_d   = wrap_next(head_q);
        count_d  = count_q - 1'b1;
      end else if (fresh_q < CountMax) begin
        new_id_d   = fresh_q[ID_W-1:0];
        bits_we    = 1'b1;
        bits_waddr = fresh_q[ID_W-1:0];
        fresh_d    = fresh_q + 1'b1;
      end else begin
        status_d = ST_NO_FREE;
      end
    end else if (action_q == ACT_DESTROY || action_q == ACT_SET ||
                 action_q == ACT_REMOVE || action_q == ACT_TEST) begin
      priority if (!ent_ok) begin
        status_d = ST_BAD_ENTITY;
      end else if (action_q == ACT_DESTROY) begin
        if (count_q >= CountMax) begin
          status_d = ST_QUEUE_FULL;
        end else begin
          fifo_we = 1'b1;
          tail_d  = wrap_next(tail_q);
          count_d = count_q + 1'b1;
          bits_we = 1'b1;
        end
      end else if (!comp_ok) begin
        status_d = ST_BAD_COMPONENT;
      end else if (action_q == ACT_SET) begin
        bits_we    = 1'b1;
        bits_wdata = bits_rd_q | mask;
      end else if (action_q == ACT_REMOVE) begin
        bits_we    = 1'b1;
        bits_wdata = bits_rd_q & ~mask;
      end else begin
        has_d = |(bits_rd_q & mask);
      end
    end else begin
      // unknown action: no change, plain ok result
      status_d = ST_OK;
    end
  end

  // Advance counters and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.execute) begin
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Latch the transaction and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      ent_q    <= entity_id_i;
      comp_q   <= component_idx_i;
    end
    if (cmd_i.execute) begin
      new_id_q <= new_id_d;
      has_q    <= has_d;
      status_q <= status_d;
    end
  end

  // Recycle FIFO memory: read at the head on capture, write at the tail on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fifo_rd_q <= fifo_mem[head_q];
    end
    if (cmd_i.execute && fifo_we) begin
      fifo_mem[tail_q] <= ent_q;
    end
  end

  // Component bitmap memory: read the entity on capture, write back on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bits_rd_q <= bits_mem[entity_id_i];
    end
    if (cmd_i.execute && bits_we) begin
      bits_mem[bits_waddr] <= bits_wdata;
    end
  end

  assign new_entity_id_o = new_id_q;
  assign has_component_o = has_q;
  assign status_o        = status_q;

endmodule

// ===== hw/rtl/eida_checker.sv =====
// Port-level checker for the entity identifier allocator, bound to the top level.
`timescale 1ns / 1ps

module eida_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Two transactions are never accepted on consecutive edges
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // A failing status never carries an identifier
  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:9] == 3'd0 || m_axis_tdata[7:0] == 8'd0))
    else $error("identifier given with error status");

  // A set component flag only comes with an ok status
  a_has_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[11:9] == 3'd0))
    else $error("has_component with error status");

  // Status codes stay in range and the padding bits stay zero
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:9] <= 3'd4 && m_axis_tdata[15:12] == 4'd0))
    else $error("bad status code or padding");

endmodule

bind entity_id_allocator_with_components eida_checker u_eida_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
